>>> hdl/dual_pool_free_list_allocator_unit_assert.svh
// Assertion macros shared by the allocator checker
`ifndef DUAL_POOL_FREE_LIST_ALLOCATOR_UNIT_ASSERT_SVH
`define DUAL_POOL_FREE_LIST_ALLOCATOR_UNIT_ASSERT_SVH

// check a property while out of reset
`define DPFL_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check a property on every edge, reset included
`define DPFL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/dpfl_pkg.sv
// Shared types and constants of the dual pool free-list allocator
package dpfl_pkg;

    localparam int SLOT_W = 10;
    localparam int CNT_W  = 11;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef enum logic [1:0] {
        STS_DONE  = 2'd0,
        STS_EMPTY = 2'd1,
        STS_RANGE = 2'd2
    } t_status;

    typedef struct packed {
        logic              clr_en;
        logic [CNT_W-1:0]  clr_cnt;
        logic              alloc_go;
        logic              free_go;
        logic [SLOT_W-1:0] free_idx;
    } t_pool_cmd;

    typedef struct packed {
        logic              empty;
        logic [SLOT_W-1:0] head;
    } t_pool_sts;

endpackage

>>> hdl/dual_pool_free_list_allocator_unit.sv
// Top level of the dual pool free-list slot allocator
//
//  Channel  Dir  tdata (low bit up)         tuser (low bit up)
//  s_axis   in   [9:0] slot_index           [0] action, [1] pool
//  m_axis   out  [9:0] granted_slot         [1:0] status
//
// Each word is accepted in ST_IDLE; in ST_EXEC the head link comes out of the pool RAM
// (registered read), the pool is updated and the result registered.
// After reset a clearing pass over every slot of both pools writes the
// initial links; s_axis_tready stays low until it ends.
// A stalled m_axis holds the finished word; the unit waits until it can be replaced.
module dual_pool_free_list_allocator_unit import dpfl_pkg::*; #(
    parameter int PLAYER_SLOTS = 64,
    parameter int ENEMY_SLOTS  = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // [9:0] slot_index, [15:10] zero
    input  logic [1:0]  s_axis_tuser,  // [0] action, [1] pool
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // [9:0] granted_slot, [15:10] zero
    output logic [1:0]  m_axis_tuser   // [1:0] status
);

    localparam int MAX_SLOTS = (PLAYER_SLOTS > ENEMY_SLOTS) ? PLAYER_SLOTS : ENEMY_SLOTS;
    localparam int CLR_W     = $clog2(MAX_SLOTS + 1);

    t_state            r_state, n_state;
    logic [CLR_W-1:0]  r_clr_cnt;
    logic              r_req_action;
    logic              r_req_pool;
    logic [SLOT_W-1:0] r_req_idx;
    logic              r_out_valid;
    logic [SLOT_W-1:0] r_out_slot;
    t_status           r_out_status;

    t_pool_cmd         w_p_cmd, w_e_cmd;
    t_pool_sts         w_p_sts, w_e_sts;
    t_pool_sts         w_sel_sts;
    logic              w_accept;
    logic              w_complete;
    logic              w_in_range;
    logic              w_alloc_go;
    logic              w_free_go;
    logic [SLOT_W-1:0] n_out_slot;
    t_status           n_out_status;

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_complete = (r_state == ST_EXEC) && (!r_out_valid || m_axis_tready);
    assign w_sel_sts  = r_req_pool ? w_p_sts : w_e_sts;
    assign w_in_range = r_req_pool ? ({1'b0, r_req_idx} < CNT_W'(PLAYER_SLOTS))
                                   : ({1'b0, r_req_idx} < CNT_W'(ENEMY_SLOTS));

    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_cnt == CLR_W'(MAX_SLOTS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (w_complete) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_cnt <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + CLR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req_action <= s_axis_tuser[0];
            r_req_pool   <= s_axis_tuser[1];
            r_req_idx    <= s_axis_tdata[SLOT_W-1:0];
        end
    end

    always_comb begin
        w_alloc_go   = 1'b0;
        w_free_go    = 1'b0;
        n_out_slot   = '0;
        n_out_status = STS_DONE;
        if (!r_req_action) begin
            if (w_sel_sts.empty) begin
                n_out_status = STS_EMPTY;
            end else begin
                w_alloc_go = w_complete;
                n_out_slot = w_sel_sts.head;
            end
        end else begin
            if (!w_in_range) begin
                n_out_status = STS_RANGE;
            end else begin
                w_free_go = w_complete;
            end
        end
    end

    always_comb begin
        w_p_cmd.clr_en   = (r_state == ST_CLEAR);
        w_p_cmd.clr_cnt  = CNT_W'(r_clr_cnt);
        w_p_cmd.alloc_go = w_alloc_go && r_req_pool;
        w_p_cmd.free_go  = w_free_go && r_req_pool;
        w_p_cmd.free_idx = r_req_idx;
        w_e_cmd.clr_en   = (r_state == ST_CLEAR);
        w_e_cmd.clr_cnt  = CNT_W'(r_clr_cnt);
        w_e_cmd.alloc_go = w_alloc_go && !r_req_pool;
        w_e_cmd.free_go  = w_free_go && !r_req_pool;
        w_e_cmd.free_idx = r_req_idx;
    end

    dpfl_pool #(
        .SLOTS (PLAYER_SLOTS)
    ) u_player_pool (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_p_cmd),
        .o_sts   (w_p_sts)
    );

    dpfl_pool #(
        .SLOTS (ENEMY_SLOTS)
    ) u_enemy_pool (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_e_cmd),
        .o_sts   (w_e_sts)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_complete) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_complete) begin
            r_out_slot   <= n_out_slot;
            r_out_status <= n_out_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b0, r_out_slot};
    assign m_axis_tuser  = r_out_status;

endmodule

>>> hdl/dpfl_ram.sv
// Generic single write port RAM with registered read
module dpfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/dpfl_pool.sv
// One slot pool: head register and link/used memory with read-modify-write
module dpfl_pool import dpfl_pkg::*; #(
    parameter int SLOTS = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_pool_cmd i_cmd,
    output t_pool_sts o_sts
);

    localparam int AW = $clog2(SLOTS);
    localparam int HW = $clog2(SLOTS + 1);
    localparam int DW = HW + 1;

    logic [HW-1:0] r_head;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [DW-1:0] w_wdata;
    logic [DW-1:0] w_rdata;
    logic [HW-1:0] w_link;

    assign w_link = w_rdata[HW-1:0];

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_head[AW-1:0];
        w_wdata = {1'b0, r_head};
        if (i_cmd.clr_en && (i_cmd.clr_cnt < CNT_W'(SLOTS))) begin
            w_we    = 1'b1;
            w_waddr = AW'(i_cmd.clr_cnt);
            w_wdata = {1'b0, HW'(i_cmd.clr_cnt + CNT_W'(1))};
        end else if (i_cmd.alloc_go) begin
            w_we    = 1'b1;
            w_waddr = r_head[AW-1:0];
            w_wdata = {1'b1, w_link};
        end else if (i_cmd.free_go) begin
            w_we    = 1'b1;
            w_waddr = AW'(i_cmd.free_idx);
            w_wdata = {1'b0, r_head};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
        end else if (i_cmd.alloc_go) begin
            r_head <= w_link;
        end else if (i_cmd.free_go) begin
            r_head <= HW'(i_cmd.free_idx);
        end
    end

    dpfl_ram #(
        .WIDTH (DW),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_head[AW-1:0]),
        .o_rdata (w_rdata)
    );

    assign o_sts.empty = (r_head == HW'(SLOTS));
    assign o_sts.head  = SLOT_W'(r_head);

endmodule

>>> hdl/dpfl_checker.sv
// Port-level checker of the allocator, bound to the top level
`include "dual_pool_free_list_allocator_unit_assert.svh"

module dpfl_checker import dpfl_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        i_s_tready,
    input logic        i_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] i_m_tdata,
    input logic [1:0]  i_m_tuser
);

    `DPFL_ASSERT(a_out_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser), "stalled output word changed")
    `DPFL_ASSERT(a_one_in_flight, i_clk, i_rst_n, i_s_tvalid && i_s_tready |=> !i_s_tready, "input taken on back-to-back cycles")
    `DPFL_ASSERT(a_fail_zero_slot, i_clk, i_rst_n, i_m_tvalid && (i_m_tuser != STS_DONE) |-> (i_m_tdata == 16'd0), "failed word carries a slot")
    `DPFL_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !i_s_tready && !i_m_tvalid, "unit active right after reset")

endmodule

bind dual_pool_free_list_allocator_unit dpfl_checker u_dpfl_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_axis_tvalid),
    .i_s_tready (s_axis_tready),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tuser  (m_axis_tuser)
);
